// ===== design/serial_frame_encoder_macros.svh =====
// assertion macros for the serial frame encoder checker
// expects clk and arst_n in the scope where a macro is used
`ifndef SERIAL_FRAME_ENCODER_MACROS_SVH
`define SERIAL_FRAME_ENCODER_MACROS_SVH

// same-cycle implication, off while reset is active
`define SFE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is active
`define SFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sfe_pkg.sv =====
// shared types and constants of the serial frame encoder
// no dependencies
`default_nettype none

package sfe_pkg;

	localparam logic [7:0] CH_START = 8'h23;
	localparam logic [7:0] CH_ADDR  = 8'h61;
	localparam logic [7:0] CH_BASE  = 8'h3D;
	localparam logic [7:0] CH_END   = 8'h0D;

	// character slots of one job, in transmit order
	localparam int NSLOT  = 10;
	localparam int SLOT_W = 4;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [NSLOT-1:0]  slot_mask_t;

	localparam slot_t SLOT_START = 4'd0;
	localparam slot_t SLOT_ADDR  = 4'd1;
	localparam slot_t SLOT_CMD   = 4'd2;
	localparam slot_t SLOT_G0    = 4'd3;
	localparam slot_t SLOT_G1    = 4'd4;
	localparam slot_t SLOT_G2    = 4'd5;
	localparam slot_t SLOT_G3    = 4'd6;
	localparam slot_t SLOT_SUMHI = 4'd7;
	localparam slot_t SLOT_SUMLO = 4'd8;
	localparam slot_t SLOT_CR    = 4'd9;

	// job queue between front and back, depth a power of two
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic       hdr;
		logic       grp;
		logic       trl;
		logic [7:0] address;
		logic [7:0] command;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} job_t;

endpackage

`default_nettype wire

// ===== design/sfe_queue.sv =====
// short job queue that decouples the front from the back
// depends on sfe_pkg
`default_nettype none

module sfe_queue
	import sfe_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  push,
	input  job_t push_job,
	output logic full,
	input  wire  pop,
	output job_t head_job,
	output logic not_empty
);

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_job  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/sfe_front.sv =====
// front: accepts items, tracks frame and byte grouping, builds jobs
// depends on sfe_pkg
`default_nettype none

module sfe_front
	import sfe_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] payload_byte,
	input  wire        has_data,
	input  wire        last,
	input  wire  [7:0] address,
	input  wire  [7:0] command,
	input  wire        q_full,
	output logic       q_push,
	output job_t       q_job
);

	logic        in_frame_q;
	logic [1:0]  gc_q;
	logic [15:0] held_q;

	logic        accept;
	logic        full_grp;
	logic [1:0]  gc_mid;
	logic [15:0] held_mid;
	logic        pad_grp;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign full_grp = has_data && (gc_q == 2'd2);

	always_comb begin
		gc_mid   = gc_q;
		held_mid = held_q;
		if (has_data) begin
			if (full_grp) begin
				gc_mid   = 2'd0;
				held_mid = '0;
			end else begin
				gc_mid   = gc_q + 2'd1;
				held_mid = {held_q[7:0], payload_byte};
			end
		end
	end

	assign pad_grp = last && (gc_mid != 2'd0);

	always_comb begin
		q_job         = '0;
		q_job.hdr     = !in_frame_q;
		q_job.grp     = full_grp || pad_grp;
		q_job.trl     = last;
		q_job.address = address;
		q_job.command = command;
		if (full_grp) begin
			q_job.b0 = held_q[15:8];
			q_job.b1 = held_q[7:0];
			q_job.b2 = payload_byte;
		end else if (gc_mid == 2'd1) begin
			q_job.b0 = held_mid[7:0];
		end else begin
			q_job.b0 = held_mid[15:8];
			q_job.b1 = held_mid[7:0];
		end
	end

	// an item that adds a held byte only produces no job
	assign q_push = accept && (q_job.hdr || q_job.grp || q_job.trl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			gc_q       <= 2'd0;
			held_q     <= '0;
		end else if (accept) begin
			in_frame_q <= !last;
			gc_q       <= last ? 2'd0 : gc_mid;
			held_q     <= last ? 16'd0 : held_mid;
		end
	end

endmodule

`default_nettype wire

// ===== design/sfe_back.sv =====
// back: walks the character slots of each job, keeps the running sum,
// and drives the output register; depends on sfe_pkg
`default_nettype none

module sfe_back
	import sfe_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        q_not_empty,
	input  job_t       q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] out_char,
	output logic       frame_end
);

	job_t       job_q;
	slot_mask_t mask_q;
	logic [11:0] sum_q;
	logic [5:0]  sum_lo_q;
	logic        out_valid_q;
	logic [7:0]  out_char_q;
	logic        frame_end_q;

	logic       adv;
	logic       busy;
	logic       emit;
	slot_t      slot;
	slot_mask_t slot_bit;
	slot_mask_t mask_after;
	logic [7:0] ch;
	logic [11:0] sum_d;

	assign adv  = !out_valid_q || !out_stall;
	assign busy = (mask_q != '0);
	assign emit = adv && busy;

	// lowest pending slot goes first
	always_comb begin
		slot     = SLOT_START;
		slot_bit = '0;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				slot     = SLOT_W'(i);
				slot_bit = slot_mask_t'(1) << i;
			end
		end
	end

	assign mask_after = emit ? (mask_q & ~slot_bit) : mask_q;
	assign q_pop      = (mask_after == '0) && q_not_empty;

	always_comb begin
		unique case (slot)
			SLOT_START: ch = CH_START;
			SLOT_ADDR:  ch = CH_ADDR + job_q.address;
			SLOT_CMD:   ch = job_q.command;
			SLOT_G0:    ch = CH_BASE + {2'b00, job_q.b0[7:2]};
			SLOT_G1:    ch = CH_BASE + {2'b00, job_q.b0[1:0], job_q.b1[7:4]};
			SLOT_G2:    ch = CH_BASE + {2'b00, job_q.b1[3:0], job_q.b2[7:6]};
			SLOT_G3:    ch = CH_BASE + {2'b00, job_q.b2[5:0]};
			SLOT_SUMHI: ch = CH_BASE + {2'b00, sum_q[11:6]};
			SLOT_SUMLO: ch = CH_BASE + {2'b00, sum_lo_q};
			SLOT_CR:    ch = CH_END;
			default:    ch = CH_END;
		endcase
	end

	// header restarts the frame sum
	assign sum_d = (slot == SLOT_START) ? {4'b0, ch} : (sum_q + {4'b0, ch});

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		if (emit) begin
			out_char_q  <= ch;
			frame_end_q <= (slot == SLOT_CR);
			sum_q       <= sum_d;
			// both checksum chars use the sum before either was sent
			if (slot == SLOT_SUMHI) begin
				sum_lo_q <= sum_q[5:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				mask_q <= {{3{q_head.trl}}, {4{q_head.grp}}, {3{q_head.hdr}}};
			end else begin
				mask_q <= mask_after;
			end
			if (adv) begin
				out_valid_q <= busy;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign frame_end = frame_end_q;

endmodule

`default_nettype wire

// ===== design/serial_frame_encoder.sv =====
// serial frame encoder: one item per cycle in while the two-entry job queue
// has room; the back's character slot sequencer sends 0 to 10 characters
// per item, one per cycle while out_stall is low. An accepted job goes from
// the queue to the back's job and slot mask registers, then out_char_q.
// reset clears frame tracking, queue pointers, slot mask and output valid.
// depends on sfe_pkg, sfe_front, sfe_queue, sfe_back
`default_nettype none

module serial_frame_encoder
	import sfe_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] payload_byte,
	input  wire        has_data,
	input  wire        last,
	input  wire  [7:0] address,
	input  wire  [7:0] command,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] out_char,
	output logic       frame_end
);

	logic q_full;
	logic q_push;
	job_t q_job;
	logic q_pop;
	job_t q_head;
	logic q_not_empty;

	sfe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.payload_byte (payload_byte),
		.has_data     (has_data),
		.last         (last),
		.address      (address),
		.command      (command),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_job        (q_job)
	);

	sfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_job),
		.full      (q_full),
		.pop       (q_pop),
		.head_job  (q_head),
		.not_empty (q_not_empty)
	);

	sfe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.frame_end   (frame_end)
	);

endmodule

`default_nettype wire

// ===== design/sfe_checker.sv =====
// port-level checker for the serial frame encoder, bound to the top level
// depends on sfe_pkg and serial_frame_encoder_macros.svh
`default_nettype none
`include "serial_frame_encoder_macros.svh"

module sfe_checker
	import sfe_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_stall,
	input wire       out_valid,
	input wire       out_stall,
	input wire [7:0] out_char,
	input wire       frame_end
);

	logic start_due_q;
	logic out_take;
	logic in_take;
	logic [2:0] in_seen_q;

	assign out_take = out_valid && !out_stall;
	assign in_take  = in_valid && !in_stall;

	// after reset or a closing item the next char must open a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_due_q <= 1'b1;
		end else if (out_take) begin
			start_due_q <= frame_end;
		end
	end

	// counts accepted items, saturating, so an output item before any input item is caught
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_seen_q <= '0;
		end else if (in_take && (in_seen_q != 3'd7)) begin
			in_seen_q <= in_seen_q + 3'd1;
		end
	end

	`SFE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_char) && $stable(frame_end), "stalled output item changed")
	`SFE_ASSERT_NOW(a_end_is_cr, out_valid && frame_end, out_char == CH_END, "frame end not on carriage return")
	`SFE_ASSERT_NOW(a_frame_start, out_take && start_due_q, out_char == CH_START && !frame_end, "frame does not open with start char")
	`SFE_ASSERT_NOW(a_no_early_out, out_valid, in_seen_q != 3'd0, "output item before any input item")

endmodule

bind serial_frame_encoder sfe_checker u_sfe_checker (.*);

`default_nettype wire

// ===== dv/serial_frame_encoder_tb.sv =====
// testbench for serial_frame_encoder: directed table, then random frames, checked
// character by character against an in-bench frame encoder model
// depends on sfe_pkg and the serial_frame_encoder rtl
`default_nettype none

module serial_frame_encoder_tb;
	import sfe_pkg::*;

	localparam int NDIR      = 22;
	localparam int RND_ITEMS = 160;
	localparam int CALM_TAIL = 30;
	localparam int LIMIT     = 200000;

	typedef struct packed {
		logic [7:0] ch;
		logic       fend;
	} sfe_char_t;

	typedef struct packed {
		logic [7:0]      pb;
		logic            hd;
		logic            lst;
		logic [7:0]      ad;
		logic [7:0]      cm;
		logic [2:0]      ntyped;
		logic [0:5][7:0] typed;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] payload_byte = '0;
	logic       has_data = 1'b0;
	logic       last = 1'b0;
	logic [7:0] address = '0;
	logic [7:0] command = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic       frame_end;

	serial_frame_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.payload_byte(payload_byte),
		.has_data(has_data),
		.last(last),
		.address(address),
		.command(command),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.frame_end(frame_end)
	);

	// frame encoder model state
	logic        frm_open = 1'b0;
	logic [1:0]  grp_cnt = '0;
	logic [15:0] held = '0;
	logic [11:0] csum = '0;

	sfe_char_t exp_chars[$];
	int        mism_cnt = 0;
	int        cyc = 0;
	logic      calm = 1'b0;
	logic      tx_idle_en = 1'b1;
	logic      rx_idle_en = 1'b1;
	int        rx_hold = 0;
	int        rx_span = 0;

	// empty frames are typed in: header, checksum of the header, carriage return
	stim_row_t dir_rows [NDIR] = '{
		'{8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 3'd6,
			{8'h23, 8'h61, 8'h00, 8'h3F, 8'h41, 8'h0D}},
		'{8'hFF, 1'b0, 1'b1, 8'hFF, 8'hFF, 3'd6,
			{8'h23, 8'h60, 8'hFF, 8'h43, 8'h3F, 8'h0D}},
		'{8'h55, 1'b0, 1'b1, 8'h9F, 8'h80, 3'd6,
			{8'h23, 8'h00, 8'h80, 8'h3F, 8'h60, 8'h0D}},
		'{8'hFF, 1'b1, 1'b0, 8'h12, 8'h34, 3'd0, '0},
		'{8'hFF, 1'b1, 1'b0, 8'h00, 8'h00, 3'd0, '0},
		'{8'hFF, 1'b1, 1'b0, 8'h00, 8'h00, 3'd0, '0},
		'{8'h00, 1'b1, 1'b1, 8'h00, 8'h00, 3'd0, '0},
		'{8'h00, 1'b0, 1'b0, 8'hC8, 8'h01, 3'd0, '0},
		'{8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 3'd0, '0},
		'{8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 3'd0, '0},
		'{8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 3'd0, '0},
		'{8'hAA, 1'b1, 1'b1, 8'h00, 8'h00, 3'd0, '0},
		'{8'h5A, 1'b1, 1'b0, 8'h3C, 8'hC3, 3'd0, '0},
		'{8'hC3, 1'b1, 1'b0, 8'h00, 8'h00, 3'd0, '0},
		'{8'hFF, 1'b0, 1'b0, 8'hFF, 8'hFF, 3'd0, '0},
		'{8'hFF, 1'b0, 1'b1, 8'hFF, 8'hFF, 3'd0, '0},
		'{8'h81, 1'b1, 1'b1, 8'h7F, 8'hFE, 3'd0, '0},
		'{8'h01, 1'b1, 1'b0, 8'hA0, 8'h0F, 3'd0, '0},
		'{8'h02, 1'b1, 1'b0, 8'h00, 8'h00, 3'd0, '0},
		'{8'h03, 1'b1, 1'b1, 8'h00, 8'h00, 3'd0, '0},
		'{8'h7E, 1'b1, 1'b0, 8'h01, 8'h7F, 3'd0, '0},
		'{8'hFF, 1'b0, 1'b1, 8'hFF, 8'hFF, 3'd0, '0}
	};

	function automatic void put_char(input logic [7:0] ch, input logic fend);
		exp_chars.push_back('{ch, fend});
		csum = csum + {4'h0, ch};
	endfunction

	// three bytes become four characters, six bits each, msb first
	function automatic void put_group(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		put_char(CH_BASE + {2'b00, a[7:2]}, 1'b0);
		put_char(CH_BASE + {2'b00, a[1:0], b[7:4]}, 1'b0);
		put_char(CH_BASE + {2'b00, b[3:0], c[7:6]}, 1'b0);
		put_char(CH_BASE + {2'b00, c[5:0]}, 1'b0);
	endfunction

	function automatic void encode_item(input stim_row_t r);
		logic [11:0] s;
		if (!frm_open) begin
			csum = '0;
			grp_cnt = '0;
			held = '0;
			put_char(CH_START, 1'b0);
			put_char(CH_ADDR + r.ad, 1'b0);
			put_char(r.cm, 1'b0);
			frm_open = 1'b1;
		end
		if (r.hd) begin
			if (grp_cnt == 2'd2) begin
				put_group(held[15:8], held[7:0], r.pb);
				grp_cnt = '0;
				held = '0;
			end else begin
				held = {held[7:0], r.pb};
				grp_cnt = grp_cnt + 2'd1;
			end
		end
		if (r.lst) begin
			if (grp_cnt == 2'd1)
				put_group(held[7:0], 8'h00, 8'h00);
			else if (grp_cnt == 2'd2)
				put_group(held[15:8], held[7:0], 8'h00);
			// checksum covers everything before its own two characters
			s = csum;
			put_char(CH_BASE + {2'b00, s[11:6]}, 1'b0);
			put_char(CH_BASE + {2'b00, s[5:0]}, 1'b0);
			put_char(CH_END, 1'b1);
			frm_open = 1'b0;
			grp_cnt = '0;
			held = '0;
			csum = '0;
		end
	endfunction

	task automatic send_item(input stim_row_t r);
		int n0;
		payload_byte <= r.pb;
		has_data <= r.hd;
		last <= r.lst;
		address <= r.ad;
		command <= r.cm;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		n0 = exp_chars.size();
		encode_item(r);
		// typed rows replace the model's characters, the model state still moves on
		if (r.ntyped != 0) begin
			while (exp_chars.size() > n0)
				void'(exp_chars.pop_back());
			for (int i = 0; i < r.ntyped; i++)
				exp_chars.push_back('{r.typed[i], (i == r.ntyped - 1)});
		end
		if (!calm && tx_idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (exp_chars.size() != 0)
			@(posedge clk);
	endtask

	function automatic stim_row_t rand_row();
		stim_row_t r;
		r.pb = 8'($urandom_range(0, 255));
		r.hd = 1'($urandom_range(0, 1));
		r.lst = 1'($urandom_range(0, 1));
		r.ad = 8'($urandom_range(0, 255));
		r.cm = 8'($urandom_range(0, 255));
		r.ntyped = '0;
		r.typed = '0;
		return r;
	endfunction

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		while (cyc < LIMIT)
			@(posedge clk) cyc++;
		$display("[serial_frame_encoder] ERROR");
		$finish;
	end

	// output side: random stall bursts and the character check
	always @(posedge clk) begin : rx_side
		sfe_char_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (exp_chars.size() == 0) begin
				$error("out_char expected none actual %02h", out_char);
				mism_cnt++;
			end else begin
				want = exp_chars.pop_front();
				if (out_char !== want.ch) begin
					$error("out_char expected %02h actual %02h", want.ch, out_char);
					mism_cnt++;
				end
				if (frame_end !== want.fend) begin
					$error("frame_end expected %0b actual %0b", want.fend, frame_end);
					mism_cnt++;
				end
			end
		end
		if (rx_span == 0) begin
			rx_idle_en <= 1'($urandom_range(0, 2) != 0);
			rx_span = $urandom_range(20, 80);
		end else begin
			rx_span--;
		end
		if (rx_hold > 0) begin
			rx_hold--;
		end else if (!calm && rx_idle_en && $urandom_range(0, 4) == 0) begin
			out_stall <= 1'b1;
			rx_hold = $urandom_range(0, 5);
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin : tx_side
		stim_row_t r;
		int        rnd_sent;
		int        flen;
		logic      mid_drained;
		rnd_sent = 0;
		mid_drained = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NDIR; i++)
			send_item(dir_rows[i]);
		hold_until_drained();

		while (rnd_sent < RND_ITEMS) begin
			if (rnd_sent >= RND_ITEMS - CALM_TAIL)
				calm = 1'b1;
			tx_idle_en = 1'($urandom_range(0, 2) != 0);
			if (!mid_drained && rnd_sent >= RND_ITEMS / 2) begin
				hold_until_drained();
				mid_drained = 1'b1;
			end
			if ($urandom_range(0, 6) != 0) begin
				// well-formed frame: mostly data items, closed by last
				flen = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
					: $urandom_range(1, 7);
				for (int k = 0; k < flen; k++) begin
					r = rand_row();
					r.hd = 1'($urandom_range(0, 5) != 0);
					r.lst = (k == flen - 1);
					send_item(r);
					rnd_sent++;
				end
			end else begin
				r = rand_row();
				send_item(r);
				rnd_sent++;
			end
		end

		hold_until_drained();
		repeat (30) @(posedge clk);
		if (mism_cnt == 0)
			$display("[serial_frame_encoder] OK");
		else
			$display("[serial_frame_encoder] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/sfe_pkg.sv
design/sfe_queue.sv
design/sfe_front.sv
design/sfe_back.sv
design/serial_frame_encoder.sv
design/sfe_checker.sv
dv/serial_frame_encoder_tb.sv
